// ----- hdl/bce_pkg.sv -----
// Package: shared constants, types and the knot helper for the B-spline evaluator
`timescale 1ns / 1ps
package bce_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int MAX_DEGREE  = 5;
  localparam int COORD_WIDTH = 32;
  localparam int AW          = $clog2(MAX_POINTS);
  localparam int ROT         = MAX_DEGREE + 1;     // working register count
  localparam int DW          = 45;                 // holds +-2^43
  localparam int MAW         = DW + 1;             // multiplier operand a
  localparam int MBW         = 21;                 // multiplier operand b
  localparam int PRW         = MAW + MBW;          // product / accumulator
  localparam int NUMW        = PRW;                // divider dividend
  localparam int DENW        = 20;                 // divider divisor
  localparam int QW          = NUMW + 2;           // 2*num + den
  localparam int CNTW        = $clog2(QW + 1);
  localparam int TW          = 23;                 // t = u * spans

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_DEGREE      = 2'd1;

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_EVAL = 1'b1;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_BAD = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  localparam logic signed [QW-1:0] INNER_LIM = QW'(64'sh0000_0800_0000_0000);
  localparam logic signed [QW-1:0] INNER_NEG = -INNER_LIM;
  localparam logic signed [DW-1:0] OUT_MAX =
    {{(DW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [DW-1:0] OUT_MIN = ~OUT_MAX;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_FWAIT,
    S_STEP,
    S_MUL1,
    S_MUL2,
    S_DIVGO,
    S_DIVW,
    S_AXIS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   go;
    logic signed [NUMW-1:0] num;
    logic        [DENW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] quot;
  } div_resp_t;

  // clamped uniform knot in span units: clamp(i - p, 0, spans)
  function automatic logic [6:0] knot_at(input logic [8:0] i, input logic [2:0] p,
                                         input logic [6:0] sp);
    logic [8:0] v;
    begin
      v = i - {6'd0, p};
      if (i < {6'd0, p}) return 7'd0;
      if (v > {2'd0, sp}) return sp;
      return v[6:0];
    end
  endfunction

endpackage

// ----- hdl/bce_ram.sv -----
// Generic single-write, registered-read RAM
`timescale 1ns / 1ps
module bce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bce_div.sv -----
// Radix-2 restoring divider, round to nearest with halves toward plus infinity
`timescale 1ns / 1ps
module bce_div (
  input  logic               clk,
  input  logic               rst,
  input  bce_pkg::div_req_t  req,
  output bce_pkg::div_resp_t resp
);

  logic                       running;
  logic [bce_pkg::CNTW-1:0]   cnt;
  logic [bce_pkg::QW-1:0]     work;
  logic [bce_pkg::DENW:0]     rem;
  logic [bce_pkg::DENW:0]     dd;
  logic                       neg;
  logic                       done_r;
  logic signed [bce_pkg::QW-1:0] quot_r;

  logic signed [bce_pkg::QW-1:0] nn;
  logic [bce_pkg::QW-1:0]     mag;
  logic [bce_pkg::DENW:0]     dd_in;
  logic [bce_pkg::DENW+1:0]   rem_sh;
  logic                       ge;
  logic [bce_pkg::DENW+1:0]   rem_sub;

  // round(num/den) = floor((2*num + den) / (2*den))
  always_comb begin
    dd_in   = {req.den, 1'b0};
    nn      = {req.num[bce_pkg::NUMW-1], req.num, 1'b0} + bce_pkg::QW'(req.den);
    // floor of a negative dividend: -ceil(|n|/d) = -floor((|n| + d - 1) / d)
    mag     = nn[bce_pkg::QW-1] ? (~nn + bce_pkg::QW'(dd_in)) : nn;
    rem_sh  = {rem, work[bce_pkg::QW-1]};
    ge      = rem_sh >= {1'b0, dd};
    rem_sub = rem_sh - {1'b0, dd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_r  <= 1'b0;
      cnt     <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go && !running) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == bce_pkg::CNTW'(bce_pkg::QW - 1)) begin
          running <= 1'b0;
          done_r  <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !running) begin
      work <= mag;
      rem  <= '0;
      dd   <= dd_in;
      neg  <= nn[bce_pkg::QW-1];
    end else if (running) begin
      rem  <= ge ? rem_sub[bce_pkg::DENW:0] : rem_sh[bce_pkg::DENW:0];
      work <= {work[bce_pkg::QW-2:0], ge};
    end
    if (running && cnt == bce_pkg::CNTW'(bce_pkg::QW - 1)) begin
      quot_r <= neg ? -$signed({work[bce_pkg::QW-2:0], ge})
                    : $signed({work[bce_pkg::QW-2:0], ge});
    end
  end

  assign resp.done = done_r;
  assign resp.quot = quot_r;

endmodule

// ----- hdl/bspline_curve_evaluate.sv -----
// Top level: sequencer, working registers and shared multiplier of the B-spline evaluator
//
//  channel   dir  handshake             payload
//  -------   ---  --------------------  --------------------------------------------
//  command   in   start & !busy         func point_index coord_x/y/z param_u deriv_order
//  result    out  done (one cycle)      out_x out_y out_z status
//  config    in   cfg_we                cfg_index cfg_data
//
//  A load gives no result; a rejected evaluate raises done in the cycle after acceptance.
//  Otherwise each axis fetches its points and walks the recursion slots (6 per level);
//  an active derivative or de Boor slot runs the shared multiplier and the 69-step
//  serial divider, and the axis ends in an output state. busy stays high for the whole
//  evaluate. Synchronous reset clears control and sets config to 4 points, degree 3;
//  the point store is not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps
module bspline_curve_evaluate (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   func,
  input  logic [5:0]                             point_index,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] coord_x,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] coord_y,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] coord_z,
  input  logic [15:0]                            param_u,
  input  logic [2:0]                             deriv_order,
  output logic                                   done,
  output logic signed [bce_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [bce_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [bce_pkg::COORD_WIDTH-1:0] out_z,
  output logic [1:0]                             status,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [6:0]                             cfg_data
);

  localparam int CW = bce_pkg::COORD_WIDTH;
  localparam int DW = bce_pkg::DW;

  bce_pkg::state_t state, state_next;

  logic [6:0] point_count;
  logic [2:0] curve_degree;

  logic [2:0]          deg, kord, qd;
  logic [6:0]          spans;
  logic [5:0]          seg;
  logic [bce_pkg::TW-1:0] tpar;
  logic [1:0]          ax;
  logic [2:0]          lvl, m;
  logic                boor;
  logic                sat;
  logic signed [DW-1:0] d [bce_pkg::ROT];
  logic signed [bce_pkg::PRW-1:0] acc;
  logic [bce_pkg::DENW-1:0] den_r, a_r;

  logic accept, ev, bad;
  logic [6:0] spans_in;
  logic [bce_pkg::TW-1:0] t_in;

  logic [3*CW-1:0] ram_rdata;
  logic [bce_pkg::AW-1:0] ram_raddr;

  bce_pkg::div_req_t  div_req;
  bce_pkg::div_resp_t div_resp;

  // step decode
  logic [2:0] j_cur;
  logic [8:0] i_d, i_b;
  logic [6:0] kd_hi, kd_lo, kb_hi, kb_lo;
  logic       act_d, act_b, den_pos, step_act;
  logic [bce_pkg::DENW-1:0] den_step, a_step;
  logic signed [24:0] a_raw;
  logic [9:0] factor;
  logic last_m, last_lvl;
  bce_pkg::state_t adv_state;

  logic signed [bce_pkg::MAW-1:0] mul_a;
  logic signed [bce_pkg::MBW-1:0] mul_b;
  logic signed [bce_pkg::PRW-1:0] prod;

  logic signed [DW-1:0] div_val, pass_val, ins_val, res_v, res_c;
  logic                 div_sat, res_sat;
  logic [CW-1:0]        ax_word;

  assign accept   = start && !busy;
  assign ev       = accept && (func == bce_pkg::FUNC_EVAL);
  assign spans_in = point_count - {4'd0, curve_degree};
  assign t_in     = bce_pkg::TW'(param_u * spans_in);
  assign bad = (point_count < 7'd2) || (point_count > 7'(bce_pkg::MAX_POINTS)) ||
               (curve_degree < 3'd1) || (curve_degree > 3'(bce_pkg::MAX_DEGREE)) ||
               (point_count <= {4'd0, curve_degree}) || (deriv_order > curve_degree);

  bce_ram #(
    .WIDTH(3 * CW),
    .DEPTH(bce_pkg::MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (accept && (func == bce_pkg::FUNC_LOAD)),
    .waddr(point_index),
    .wdata({coord_z, coord_y, coord_x}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = bce_pkg::AW'(seg + {3'd0, m});

  bce_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .resp(div_resp)
  );

  always_comb begin
    j_cur  = boor ? (3'(bce_pkg::ROT - 1) - m) : m;
    i_d    = {3'd0, seg} + {6'd0, m};
    kd_hi  = bce_pkg::knot_at(i_d + {6'd0, deg} + 9'd1, deg, spans);
    kd_lo  = bce_pkg::knot_at(i_d + {6'd0, lvl}, deg, spans);
    i_b    = {3'd0, seg} + {6'd0, j_cur};
    kb_lo  = bce_pkg::knot_at(i_b + {6'd0, kord}, deg, spans);
    kb_hi  = bce_pkg::knot_at(i_b + 9'd1 + {6'd0, qd} - {6'd0, lvl} + {6'd0, kord},
                              deg, spans);
    act_d  = m <= (deg - lvl);
    act_b  = (j_cur >= lvl) && (j_cur <= qd);
    factor = spans * ({7'd0, deg} - {7'd0, lvl} + 10'd1);
    a_raw  = $signed({2'b0, tpar}) - $signed({2'b0, kb_lo, 16'd0});
    if (boor) begin
      den_pos  = kb_hi > kb_lo;
      den_step = {1'b0, 3'(kb_hi - kb_lo), 16'd0};
      if (a_raw < 0) begin
        a_step = '0;
      end else if (a_raw > $signed({5'd0, den_step})) begin
        a_step = den_step;
      end else begin
        a_step = a_raw[bce_pkg::DENW-1:0];
      end
      step_act = act_b && den_pos;
      pass_val = act_b ? '0 : d[bce_pkg::ROT-1];
    end else begin
      den_pos  = kd_hi > kd_lo;
      den_step = bce_pkg::DENW'(kd_hi - kd_lo);
      a_step   = '0;
      step_act = act_d && den_pos;
      pass_val = act_d ? '0 : d[0];
    end
    last_m    = m == 3'(bce_pkg::ROT - 1);
    last_lvl  = boor ? (lvl == qd) : (lvl == kord);
    adv_state = (last_m && last_lvl && (boor || qd == 3'd0)) ? bce_pkg::S_AXIS
                                                             : bce_pkg::S_STEP;
  end

  // shared multiplier
  always_comb begin
    mul_a = bce_pkg::MAW'(d[bce_pkg::ROT-1]);
    mul_b = $signed({1'b0, a_r});
    if (state == bce_pkg::S_MUL1) begin
      if (boor) begin
        mul_a = bce_pkg::MAW'(d[bce_pkg::ROT-2]);
        mul_b = $signed({1'b0, den_r - a_r});
      end else begin
        mul_a = bce_pkg::MAW'(d[1]) - bce_pkg::MAW'(d[0]);
        mul_b = $signed({11'd0, factor});
      end
    end
    prod = mul_a * mul_b;
  end

  always_comb begin
    div_sat = 1'b0;
    if (boor) begin
      div_val = div_resp.quot[DW-1:0];
    end else if (div_resp.quot > bce_pkg::INNER_LIM) begin
      div_val = DW'(bce_pkg::INNER_LIM);
      div_sat = 1'b1;
    end else if (div_resp.quot < bce_pkg::INNER_NEG) begin
      div_val = DW'(bce_pkg::INNER_NEG);
      div_sat = 1'b1;
    end else begin
      div_val = div_resp.quot[DW-1:0];
    end
    ins_val = (state == bce_pkg::S_DIVW) ? div_val : pass_val;
    res_v   = d[qd];
    res_sat = 1'b0;
    if (res_v > bce_pkg::OUT_MAX) begin
      res_c   = bce_pkg::OUT_MAX;
      res_sat = 1'b1;
    end else if (res_v < bce_pkg::OUT_MIN) begin
      res_c   = bce_pkg::OUT_MIN;
      res_sat = 1'b1;
    end else begin
      res_c = res_v;
    end
    case (ax)
      2'd0:    ax_word = ram_rdata[CW-1:0];
      2'd1:    ax_word = ram_rdata[2*CW-1:CW];
      default: ax_word = ram_rdata[3*CW-1:2*CW];
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bce_pkg::S_IDLE:  if (ev) state_next = bad ? bce_pkg::S_DONE : bce_pkg::S_FETCH;
      bce_pkg::S_FETCH: state_next = bce_pkg::S_FWAIT;
      bce_pkg::S_FWAIT: begin
        if (!last_m) state_next = bce_pkg::S_FETCH;
        else if (kord != 3'd0 || qd != 3'd0) state_next = bce_pkg::S_STEP;
        else state_next = bce_pkg::S_AXIS;
      end
      bce_pkg::S_STEP:  state_next = step_act ? bce_pkg::S_MUL1 : adv_state;
      bce_pkg::S_MUL1:  state_next = boor ? bce_pkg::S_MUL2 : bce_pkg::S_DIVGO;
      bce_pkg::S_MUL2:  state_next = bce_pkg::S_DIVGO;
      bce_pkg::S_DIVGO: state_next = bce_pkg::S_DIVW;
      bce_pkg::S_DIVW:  if (div_resp.done) state_next = adv_state;
      bce_pkg::S_AXIS:  state_next = (ax == 2'd2) ? bce_pkg::S_DONE : bce_pkg::S_FETCH;
      bce_pkg::S_DONE:  state_next = bce_pkg::S_IDLE;
      default:          state_next = bce_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    div_req.go  = 1'b0;
    div_req.num = acc;
    div_req.den = den_r;
    case (state)
      bce_pkg::S_IDLE:  busy = 1'b0;
      bce_pkg::S_DIVGO: div_req.go = 1'b1;
      bce_pkg::S_DONE:  done = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bce_pkg::S_IDLE;
      point_count  <= 7'd4;
      curve_degree <= 3'd3;
      ax           <= '0;
      m            <= '0;
      lvl          <= 3'd1;
      boor         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == bce_pkg::REG_POINT_COUNT) point_count <= cfg_data;
      if (cfg_we && cfg_index == bce_pkg::REG_DEGREE)      curve_degree <= cfg_data[2:0];
      case (state)
        bce_pkg::S_IDLE: begin
          ax <= '0;
          m  <= '0;
        end
        bce_pkg::S_FWAIT: begin
          m    <= last_m ? 3'd0 : m + 3'd1;
          lvl  <= 3'd1;
          boor <= kord == 3'd0;
        end
        bce_pkg::S_STEP, bce_pkg::S_DIVW: begin
          if ((state == bce_pkg::S_STEP && !step_act) ||
              (state == bce_pkg::S_DIVW && div_resp.done)) begin
            if (last_m) begin
              m <= '0;
              if (last_lvl) begin
                lvl  <= 3'd1;
                boor <= 1'b1;
              end else begin
                lvl <= lvl + 3'd1;
              end
            end else begin
              m <= m + 3'd1;
            end
          end
        end
        bce_pkg::S_AXIS: begin
          ax <= ax + 2'd1;
          m  <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      bce_pkg::S_IDLE: begin
        if (ev) begin
          deg    <= curve_degree;
          kord   <= deriv_order;
          qd     <= curve_degree - deriv_order;
          spans  <= spans_in;
          tpar   <= t_in;
          seg    <= t_in[21:16];
          sat    <= 1'b0;
          if (bad) begin
            out_x  <= '0;
            out_y  <= '0;
            out_z  <= '0;
            status <= bce_pkg::STAT_BAD;
          end
        end
      end
      bce_pkg::S_FWAIT: begin
        for (int i = 0; i < bce_pkg::ROT - 1; i++) d[i] <= d[i+1];
        d[bce_pkg::ROT-1] <= {{(DW - CW){ax_word[CW-1]}}, ax_word};
      end
      bce_pkg::S_STEP, bce_pkg::S_DIVW: begin
        if (state == bce_pkg::S_STEP) begin
          den_r <= den_step;
          a_r   <= a_step;
        end
        if ((state == bce_pkg::S_STEP && !step_act) ||
            (state == bce_pkg::S_DIVW && div_resp.done)) begin
          if (state == bce_pkg::S_DIVW && div_sat) sat <= 1'b1;
          if (boor) begin
            for (int i = 1; i < bce_pkg::ROT; i++) d[i] <= d[i-1];
            d[0] <= ins_val;
          end else begin
            for (int i = 0; i < bce_pkg::ROT - 1; i++) d[i] <= d[i+1];
            d[bce_pkg::ROT-1] <= ins_val;
          end
        end
      end
      bce_pkg::S_MUL1: acc <= prod;
      bce_pkg::S_MUL2: acc <= acc + prod;
      bce_pkg::S_AXIS: begin
        case (ax)
          2'd0:    out_x <= res_c[CW-1:0];
          2'd1:    out_y <= res_c[CW-1:0];
          default: out_z <= res_c[CW-1:0];
        endcase
        if (res_sat) sat <= 1'b1;
        if (ax == 2'd2) status <= (sat || res_sat) ? bce_pkg::STAT_SAT : bce_pkg::STAT_OK;
      end
      default: ;
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && func == bce_pkg::FUNC_EVAL))
    else $error("busy rose without an accepted evaluate item");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> state == bce_pkg::S_DIVW)
    else $error("divider finished while sequencer was not waiting");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == bce_pkg::STAT_BAD) |-> (out_x == 0 && out_y == 0 && out_z == 0))
    else $error("rejected item returned nonzero coordinates");

endmodule

// ----- tb/sv/bspline_checker.sv -----
// Checker: watches command, config and result channels, predicts and compares results
`timescale 1ns / 1ps
module bspline_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   func,
  input  logic [5:0]                             point_index,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] coord_x,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] coord_y,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] coord_z,
  input  logic [15:0]                            param_u,
  input  logic [2:0]                             deriv_order,
  input  logic                                   done,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] out_x,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] out_y,
  input  logic signed [bce_pkg::COORD_WIDTH-1:0] out_z,
  input  logic [1:0]                             status,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [6:0]                             cfg_data,
  output int                                     errors,
  output int                                     pending
);

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic signed [bce_pkg::COORD_WIDTH-1:0] x, y, z;
    logic [1:0]                             st;
  } curve_pt_t;

  logic signed [bce_pkg::COORD_WIDTH-1:0] pts [3][bce_pkg::MAX_POINTS];
  logic [6:0]                             n_pts;
  logic [2:0]                             degree;
  curve_pt_t                              expected_pts [4];
  int                                     wr_cnt, rd_cnt;

  assign pending = wr_cnt - rd_cnt;

  function automatic wide_t knot(input int i, input int p, input int sp);
    if (i - p < 0) return 0;
    if (i - p > sp) return sp;
    return i - p;
  endfunction

  // round to nearest, halves toward +inf
  function automatic wide_t rdiv(input wide_t num, input wide_t den);
    wide_t q, r;
    q = num / den;
    r = num - q * den;
    if (r < 0) begin
      q -= 1;
      r += den;
    end
    if (r >= den - r) q += 1;
    return q;
  endfunction

  function automatic wide_t clamp_in(input wide_t v, inout bit sat);
    wide_t lim;
    lim = wide_t'(1) <<< 43;
    if (v > lim) begin
      sat = 1;
      return lim;
    end
    if (v < -lim) begin
      sat = 1;
      return -lim;
    end
    return v;
  endfunction

  function automatic wide_t axis_value(input int ax, input int s, input int sp, input int p,
                                       input int k, input wide_t t, inout bit sat);
    wide_t d[bce_pkg::MAX_DEGREE+1];
    wide_t den, a, lo, hi;
    int    q;
    q = p - k;
    for (int j = 0; j <= p; j++) d[j] = clamp_in(wide_t'(pts[ax][s+j]), sat);
    // derivative control points
    for (int r = 1; r <= k; r++)
      for (int j = 0; j <= p - r; j++) begin
        den = knot(s + j + p + 1, p, sp) - knot(s + j + r, p, sp);
        if (den <= 0) d[j] = 0;
        else d[j] = clamp_in(rdiv((d[j+1] - d[j]) * sp * (p - r + 1), den), sat);
      end
    // de Boor over the reduced knot vector
    for (int r = 1; r <= q; r++)
      for (int j = q; j >= r; j--) begin
        lo  = knot(s + j + k, p, sp);
        hi  = knot(s + j + 1 + q - r + k, p, sp);
        den = (hi - lo) * 65536;
        a   = t - lo * 65536;
        if (den <= 0) begin
          d[j] = 0;
        end else begin
          if (a < 0) a = 0;
          if (a > den) a = den;
          d[j] = rdiv((den - a) * d[j-1] + a * d[j], den);
        end
      end
    return d[q];
  endfunction

  function automatic logic signed [bce_pkg::COORD_WIDTH-1:0] to_out(input wide_t v,
                                                                     inout bit sat);
    wide_t hi;
    hi = (wide_t'(1) <<< (bce_pkg::COORD_WIDTH - 1)) - 1;
    if (v > hi) begin
      sat = 1;
      v = hi;
    end
    if (v < -hi - 1) begin
      sat = 1;
      v = -hi - 1;
    end
    return v[bce_pkg::COORD_WIDTH-1:0];
  endfunction

  function automatic curve_pt_t predict_point(input logic [15:0] u, input logic [2:0] ko);
    curve_pt_t e;
    int        n, p, k, sp, s;
    wide_t     t;
    bit        sat;
    e   = '{x: '0, y: '0, z: '0, st: bce_pkg::STAT_BAD};
    n   = n_pts;
    p   = degree;
    k   = ko;
    sat = 0;
    if (n < 2 || n > bce_pkg::MAX_POINTS || p < 1 || p > bce_pkg::MAX_DEGREE ||
        n <= p || k > p) return e;
    sp  = n - p;
    t   = wide_t'(u) * sp;
    s   = int'(t >>> 16);
    e.x = to_out(axis_value(0, s, sp, p, k, t, sat), sat);
    e.y = to_out(axis_value(1, s, sp, p, k, t, sat), sat);
    e.z = to_out(axis_value(2, s, sp, p, k, t, sat), sat);
    e.st = sat ? bce_pkg::STAT_SAT : bce_pkg::STAT_OK;
    return e;
  endfunction

  always @(posedge clk) begin
    curve_pt_t e;
    if (rst) begin
      n_pts  <= 7'd4;
      degree <= 3'd3;
      errors <= 0;
      wr_cnt <= 0;
      rd_cnt <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bce_pkg::REG_POINT_COUNT) n_pts <= cfg_data;
        else if (cfg_index == bce_pkg::REG_DEGREE) degree <= cfg_data[2:0];
      end
      if (start && !busy) begin
        if (func == bce_pkg::FUNC_LOAD) begin
          pts[0][point_index] <= coord_x;
          pts[1][point_index] <= coord_y;
          pts[2][point_index] <= coord_z;
        end else begin
          expected_pts[wr_cnt % 4] <= predict_point(param_u, deriv_order);
          wr_cnt <= wr_cnt + 1;
        end
      end
      if (done) begin
        if (wr_cnt == rd_cnt) begin
          $error("result with no evaluate outstanding");
          errors <= errors + 1;
        end else begin
          e = expected_pts[rd_cnt % 4];
          rd_cnt <= rd_cnt + 1;
          if (out_x !== e.x || out_y !== e.y || out_z !== e.z || status !== e.st)
            errors <= errors + 1;
          if (out_x !== e.x) $error("out_x expected %0d actual %0d", e.x, out_x);
          if (out_y !== e.y) $error("out_y expected %0d actual %0d", e.y, out_y);
          if (out_z !== e.z) $error("out_z expected %0d actual %0d", e.z, out_z);
          if (status !== e.st) $error("status expected %0d actual %0d", e.st, status);
        end
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top: clock, reset, command and config stimulus, verdict
`timescale 1ns / 1ps
module testbench;

  logic                                   clk = 0;
  logic                                   rst = 1;
  logic                                   start = 0;
  logic                                   busy;
  logic                                   func = bce_pkg::FUNC_LOAD;
  logic [5:0]                             point_index = '0;
  logic signed [bce_pkg::COORD_WIDTH-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [15:0]                            param_u = '0;
  logic [2:0]                             deriv_order = '0;
  logic                                   done;
  logic signed [bce_pkg::COORD_WIDTH-1:0] out_x, out_y, out_z;
  logic [1:0]                             status;
  logic                                   cfg_we = 0;
  logic [1:0]                             cfg_index = '0;
  logic [6:0]                             cfg_data = '0;
  int                                     errors, pending;
  bit                                     calm = 0;
  int                                     pc[10] = '{2, 64, 64, 10, 0, 5, 3, 100, 6, 7};
  int                                     dg[10] = '{1, 5, 1, 5, 3, 0, 3, 2, 7, 2};

  always #1 clk = ~clk;

  bspline_curve_evaluate u_top (.*);

  bspline_checker u_checker (.*);

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_u();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // hold start until the block takes the item; caller sits just after a rising edge
  task automatic issue(input logic f, input logic [5:0] idx, input logic [31:0] x,
                       input logic [31:0] y, input logic [31:0] z, input logic [15:0] u,
                       input logic [2:0] k);
    start       <= 1;
    func        <= f;
    point_index <= idx;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    param_u     <= u;
    deriv_order <= k;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_pt(input logic [5:0] idx);
    issue(bce_pkg::FUNC_LOAD, idx, pick_coord(), pick_coord(), pick_coord(),
          16'($urandom), 3'($urandom));
  endtask

  task automatic evaluate(input logic [15:0] u, input logic [2:0] k);
    issue(bce_pkg::FUNC_EVAL, 6'($urandom), $urandom, $urandom, $urandom, u, k);
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 0;
    @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // fill every slot so no evaluation reads an unwritten point
    for (int i = 0; i < bce_pkg::MAX_POINTS; i++) load_pt(i[5:0]);
    issue(bce_pkg::FUNC_LOAD, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 0, 0);
    issue(bce_pkg::FUNC_LOAD, 6'd1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 0);
    issue(bce_pkg::FUNC_LOAD, 6'd63, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          16'hffff, 3'd7);
    for (int k = 0; k < 8; k++) begin
      evaluate(16'h0000, k[2:0]);
      evaluate(16'hffff, k[2:0]);
    end
    evaluate(16'h8000, 3'd0);
    evaluate(16'h5555, 3'd1);
    settle();
    // extra register indexes are ignored
    write_reg(2'd2, 7'h7f);
    write_reg(2'd3, 7'h00);
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(bce_pkg::REG_POINT_COUNT, pc[ph][6:0]);
      write_reg(bce_pkg::REG_DEGREE, dg[ph][6:0]);
      calm = (ph == 9);
      for (int i = 0; i < 32; i++) begin
        if ($urandom_range(0, 3) == 0) load_pt(6'($urandom));
        else evaluate(pick_u(), $urandom_range(0, 9) < 8
                                  ? 3'($urandom_range(0, dg[ph] & 7))
                                  : 3'($urandom_range(0, 7)));
      end
      settle();
    end
    if (errors == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
